/* rtl/usrh_pkg.sv */
// Package for the USB standard request handler: codes, words and state types.
package usrh_pkg;

	localparam int NumEndpointsDef = 16;
	localparam int CfgDataW = 8;
	localparam int CfgIdxW = 2;

	// recipients
	localparam logic [1:0] RCPT_DEVICE = 2'd0;
	localparam logic [1:0] RCPT_INTERFACE = 2'd1;
	localparam logic [1:0] RCPT_ENDPOINT = 2'd2;

	localparam logic [1:0] KIND_CLASS = 2'd1;

	// bRequest codes
	localparam logic [7:0] REQ_GET_STATUS = 8'd0;
	localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
	localparam logic [7:0] REQ_SET_FEATURE = 8'd3;
	localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
	localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
	localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
	localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;

	// descriptor types and selects
	localparam logic [7:0] DT_DEVICE = 8'd1;
	localparam logic [7:0] DT_CONFIGURATION = 8'd2;
	localparam logic [7:0] DT_STRING = 8'd3;
	localparam logic [7:0] STRING_LAST = 8'd5;
	localparam logic [2:0] DSEL_DEVICE = 3'd0;
	localparam logic [2:0] DSEL_CONFIGURATION = 3'd1;
	localparam logic [2:0] DSEL_STRING_BASE = 3'd2;

	localparam logic [15:0] FEAT_REMOTE_WAKEUP = 16'h0001;
	localparam logic [15:0] FEAT_ENDPOINT_HALT = 16'h0000;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_SELF_POWERED = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_MAX_CONFIGURATION = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_MAX_INTERFACE = 2'd2;

	typedef enum logic [2:0] {
		RSP_NONE = 3'd0,
		RSP_STALL = 3'd1,
		RSP_ACK = 3'd2,
		RSP_DATA = 3'd3,
		RSP_DESC = 3'd4
	} rsp_code_t;

	typedef enum logic [2:0] {
		CA_NONE = 3'd0,
		CA_CLEAR = 3'd1,
		CA_SET = 3'd2,
		CA_REPLACE = 3'd3,
		CA_INTERFACE = 3'd4
	} class_act_t;

	typedef enum logic [1:0] {
		EA_NONE = 2'd0,
		EA_STALL = 2'd1,
		EA_CLEAR = 2'd2
	} ep_act_t;

	typedef enum logic [1:0] {
		DS_DEFAULT = 2'd0,
		DS_ADDRESSED = 2'd1,
		DS_CONFIGURED = 2'd2
	} usb_state_t;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] request_kind;
		logic [7:0] request_code;
		logic [15:0] setup_value;
		logic [15:0] setup_index;
		logic [15:0] setup_length;
		logic class_ok;
	} req_t;

	typedef struct packed {
		logic [2:0] response;
		logic [15:0] reply_value;
		logic [15:0] reply_length;
		logic [2:0] descriptor_select;
		logic [2:0] class_action;
		logic [7:0] class_index;
		logic [7:0] old_config;
		logic address_write;
		logic [6:0] new_address;
		logic [1:0] endpoint_action;
		logic [7:0] endpoint_address;
	} rsp_t;

	typedef struct packed {
		usb_state_t usb_state;
		logic [7:0] cur_config;
		logic remote_wakeup;
		logic [6:0] usb_addr;
	} dev_regs_t;

	typedef struct packed {
		logic self_powered;
		logic [7:0] max_config;
		logic [7:0] max_interface;
	} cfg_regs_t;

endpackage

/* rtl/usrh_req_if.sv */
// Request channel: one decoded SETUP word per handshake.
interface usrh_req_if;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic [1:0] request_kind;
	logic [7:0] request_code;
	logic [15:0] setup_value;
	logic [15:0] setup_index;
	logic [15:0] setup_length;
	logic class_ok;

	modport source (output valid, action, request_kind, request_code, setup_value,
		setup_index, setup_length, class_ok, input ready);
	modport sink (input valid, action, request_kind, request_code, setup_value,
		setup_index, setup_length, class_ok, output ready);
endinterface

/* rtl/usrh_rsp_if.sv */
// Response channel: one result word per request.
interface usrh_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] response;
	logic [15:0] reply_value;
	logic [15:0] reply_length;
	logic [2:0] descriptor_select;
	logic [2:0] class_action;
	logic [7:0] class_index;
	logic [7:0] old_config;
	logic address_write;
	logic [6:0] new_address;
	logic [1:0] endpoint_action;
	logic [7:0] endpoint_address;

	modport source (output valid, response, reply_value, reply_length, descriptor_select,
		class_action, class_index, old_config, address_write, new_address,
		endpoint_action, endpoint_address, input ready);
	modport sink (input valid, response, reply_value, reply_length, descriptor_select,
		class_action, class_index, old_config, address_write, new_address,
		endpoint_action, endpoint_address, output ready);
endinterface

/* rtl/usb_standard_request_handler.sv */
// USB standard request handler: one SETUP request word in, one response word out.
// Each request is registered on acceptance and decoded against the device state; once
// the output register is free, its response word is written there. The device state,
// configuration and endpoint halt bits update on that same edge, so the following
// request already sees them. A new request is taken every cycle while the output is
// drained. While a response waits to be taken, one further request can still be taken
// into the input register, after which the input stalls.
// Configuration writes take effect on the edge they are written.
module usb_standard_request_handler #(
	parameter int NUM_ENDPOINTS = usrh_pkg::NumEndpointsDef
) (
	input logic clk,
	input logic arst_n,
	usrh_req_if.sink req,
	usrh_rsp_if.source rsp,
	input logic cfg_we,
	input logic [usrh_pkg::CfgIdxW-1:0] cfg_index,
	input logic [usrh_pkg::CfgDataW-1:0] cfg_data
);

	usrh_pkg::req_t req_s1;
	usrh_pkg::rsp_t rsp_s2;
	usrh_pkg::rsp_t rsp_w;
	usrh_pkg::dev_regs_t dev_q;
	usrh_pkg::dev_regs_t dev_nxt;
	usrh_pkg::cfg_regs_t cfg_q;
	logic [NUM_ENDPOINTS-1:0] in_halt_q;
	logic [NUM_ENDPOINTS-1:0] out_halt_q;
	logic [NUM_ENDPOINTS-1:0] in_halt_nxt;
	logic [NUM_ENDPOINTS-1:0] out_halt_nxt;
	logic vld_s1;
	logic vld_s2;
	logic take;
	logic adv;

	assign adv = vld_s1 && (!vld_s2 || rsp.ready);
	assign req.ready = !vld_s1 || adv;
	assign take = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (take) vld_s1 <= 1'b1;
			else if (adv) vld_s1 <= 1'b0;
			if (adv) vld_s2 <= 1'b1;
			else if (rsp.ready) vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1.action <= req.action;
			req_s1.request_kind <= req.request_kind;
			req_s1.request_code <= req.request_code;
			req_s1.setup_value <= req.setup_value;
			req_s1.setup_index <= req.setup_index;
			req_s1.setup_length <= req.setup_length;
			req_s1.class_ok <= req.class_ok;
		end
		if (adv) rsp_s2 <= rsp_w;
	end

	usrh_decode #(
		.NUM_ENDPOINTS(NUM_ENDPOINTS)
	) u_decode (
		.req_w(req_s1),
		.dev_q(dev_q),
		.in_halt_q(in_halt_q),
		.out_halt_q(out_halt_q),
		.cfg_q(cfg_q),
		.rsp_w(rsp_w),
		.dev_nxt(dev_nxt),
		.in_halt_nxt(in_halt_nxt),
		.out_halt_nxt(out_halt_nxt)
	);

	usrh_state #(
		.NUM_ENDPOINTS(NUM_ENDPOINTS)
	) u_state (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.upd(adv),
		.dev_nxt(dev_nxt),
		.in_halt_nxt(in_halt_nxt),
		.out_halt_nxt(out_halt_nxt),
		.dev_q(dev_q),
		.in_halt_q(in_halt_q),
		.out_halt_q(out_halt_q),
		.cfg_q(cfg_q)
	);

	assign rsp.valid = vld_s2;
	assign rsp.response = rsp_s2.response;
	assign rsp.reply_value = rsp_s2.reply_value;
	assign rsp.reply_length = rsp_s2.reply_length;
	assign rsp.descriptor_select = rsp_s2.descriptor_select;
	assign rsp.class_action = rsp_s2.class_action;
	assign rsp.class_index = rsp_s2.class_index;
	assign rsp.old_config = rsp_s2.old_config;
	assign rsp.address_write = rsp_s2.address_write;
	assign rsp.new_address = rsp_s2.new_address;
	assign rsp.endpoint_action = rsp_s2.endpoint_action;
	assign rsp.endpoint_address = rsp_s2.endpoint_address;

	a_adv_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> vld_s2)
		else $error("decoded word not held in output register");

	a_addr_ack: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && rsp_s2.address_write |-> rsp_s2.response == usrh_pkg::RSP_ACK)
		else $error("address write without status ack");

	a_cfg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		dev_q.usb_state == usrh_pkg::DS_CONFIGURED |-> dev_q.cur_config != '0)
		else $error("configured state with configuration zero");

	a_halt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(in_halt_q) && $stable(out_halt_q) && $stable(dev_q))
		else $error("device state changed without a request");

endmodule

/* rtl/usrh_state.sv */
// Device state, endpoint halt bits and configuration registers.
module usrh_state #(
	parameter int NUM_ENDPOINTS = usrh_pkg::NumEndpointsDef
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [usrh_pkg::CfgIdxW-1:0] cfg_index,
	input logic [usrh_pkg::CfgDataW-1:0] cfg_data,
	input logic upd,
	input usrh_pkg::dev_regs_t dev_nxt,
	input logic [NUM_ENDPOINTS-1:0] in_halt_nxt,
	input logic [NUM_ENDPOINTS-1:0] out_halt_nxt,
	output usrh_pkg::dev_regs_t dev_q,
	output logic [NUM_ENDPOINTS-1:0] in_halt_q,
	output logic [NUM_ENDPOINTS-1:0] out_halt_q,
	output usrh_pkg::cfg_regs_t cfg_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q.usb_state <= usrh_pkg::DS_DEFAULT;
			dev_q.cur_config <= '0;
			dev_q.remote_wakeup <= 1'b0;
			dev_q.usb_addr <= '0;
			in_halt_q <= '0;
			out_halt_q <= '0;
		end else if (upd) begin
			dev_q <= dev_nxt;
			in_halt_q <= in_halt_nxt;
			out_halt_q <= out_halt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.self_powered <= 1'b0;
			cfg_q.max_config <= 8'd1;
			cfg_q.max_interface <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				usrh_pkg::CFG_SELF_POWERED: cfg_q.self_powered <= cfg_data[0];
				usrh_pkg::CFG_MAX_CONFIGURATION: cfg_q.max_config <= cfg_data;
				usrh_pkg::CFG_MAX_INTERFACE: cfg_q.max_interface <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

/* rtl/usrh_decode.sv */
// Request decode: response word, side actions and next device state.
module usrh_decode #(
	parameter int NUM_ENDPOINTS = usrh_pkg::NumEndpointsDef
) (
	input usrh_pkg::req_t req_w,
	input usrh_pkg::dev_regs_t dev_q,
	input logic [NUM_ENDPOINTS-1:0] in_halt_q,
	input logic [NUM_ENDPOINTS-1:0] out_halt_q,
	input usrh_pkg::cfg_regs_t cfg_q,
	output usrh_pkg::rsp_t rsp_w,
	output usrh_pkg::dev_regs_t dev_nxt,
	output logic [NUM_ENDPOINTS-1:0] in_halt_nxt,
	output logic [NUM_ENDPOINTS-1:0] out_halt_nxt
);

	logic [NUM_ENDPOINTS-1:0] ep_mask;
	logic [NUM_ENDPOINTS-1:0] halt_sel;
	logic [6:0] ep_num;
	logic ep_in;
	logic active;
	logic configured;
	logic addressed;
	logic [7:0] cfg_new;
	logic [7:0] desc_type;
	logic [7:0] desc_lo;
	usrh_pkg::ep_act_t ep_cmd;

	assign ep_num = req_w.setup_index[6:0];
	assign ep_in = req_w.setup_index[7];
	assign configured = dev_q.usb_state == usrh_pkg::DS_CONFIGURED;
	assign addressed = dev_q.usb_state == usrh_pkg::DS_ADDRESSED;
	assign active = configured || addressed;
	assign cfg_new = req_w.setup_value[7:0];
	assign desc_type = req_w.setup_value[15:8];
	assign desc_lo = req_w.setup_value[7:0];
	assign halt_sel = ep_in ? in_halt_q : out_halt_q;

	always_comb begin
		for (int i = 0; i < NUM_ENDPOINTS; i++) begin
			ep_mask[i] = ep_num == 7'(i);
		end
	end

	always_comb begin
		rsp_w = '0;
		dev_nxt = dev_q;
		ep_cmd = usrh_pkg::EA_NONE;
		case (req_w.action)
			usrh_pkg::RCPT_DEVICE: begin
				case (req_w.request_code)
					usrh_pkg::REQ_GET_DESCRIPTOR: begin
						if (desc_type == usrh_pkg::DT_DEVICE) begin
							rsp_w.descriptor_select = usrh_pkg::DSEL_DEVICE;
						end else if (desc_type == usrh_pkg::DT_CONFIGURATION) begin
							rsp_w.descriptor_select = usrh_pkg::DSEL_CONFIGURATION;
						end else if (desc_type == usrh_pkg::DT_STRING &&
								desc_lo <= usrh_pkg::STRING_LAST) begin
							rsp_w.descriptor_select = desc_lo[2:0] + usrh_pkg::DSEL_STRING_BASE;
						end else begin
							rsp_w.response = usrh_pkg::RSP_STALL;
						end
						if (rsp_w.response != usrh_pkg::RSP_STALL) begin
							if (req_w.setup_length != '0) begin
								rsp_w.response = usrh_pkg::RSP_DESC;
								rsp_w.reply_length = req_w.setup_length;
							end else begin
								rsp_w.descriptor_select = '0;
							end
						end
					end
					usrh_pkg::REQ_SET_ADDRESS: begin
						if (req_w.setup_index != '0 || req_w.setup_length != '0 || configured) begin
							rsp_w.response = usrh_pkg::RSP_STALL;
						end else begin
							dev_nxt.usb_addr = req_w.setup_value[6:0];
							dev_nxt.usb_state = (req_w.setup_value[6:0] != '0) ?
								usrh_pkg::DS_ADDRESSED : usrh_pkg::DS_DEFAULT;
							rsp_w.address_write = 1'b1;
							rsp_w.new_address = req_w.setup_value[6:0];
							rsp_w.response = usrh_pkg::RSP_ACK;
						end
					end
					usrh_pkg::REQ_SET_CONFIGURATION: begin
						if (cfg_new > cfg_q.max_config) begin
							rsp_w.response = usrh_pkg::RSP_STALL;
						end else if (addressed) begin
							rsp_w.response = usrh_pkg::RSP_ACK;
							if (cfg_new != '0) begin
								dev_nxt.cur_config = cfg_new;
								dev_nxt.usb_state = usrh_pkg::DS_CONFIGURED;
								rsp_w.class_action = usrh_pkg::CA_SET;
								rsp_w.class_index = cfg_new;
								if (!req_w.class_ok) rsp_w.response = usrh_pkg::RSP_STALL;
							end
						end else if (configured) begin
							rsp_w.response = usrh_pkg::RSP_ACK;
							if (cfg_new == '0) begin
								rsp_w.class_action = usrh_pkg::CA_CLEAR;
								rsp_w.old_config = dev_q.cur_config;
								dev_nxt.usb_state = usrh_pkg::DS_ADDRESSED;
								dev_nxt.cur_config = '0;
							end else if (cfg_new != dev_q.cur_config) begin
								rsp_w.class_action = usrh_pkg::CA_REPLACE;
								rsp_w.class_index = cfg_new;
								rsp_w.old_config = dev_q.cur_config;
								dev_nxt.cur_config = cfg_new;
								if (!req_w.class_ok) rsp_w.response = usrh_pkg::RSP_STALL;
							end
						end else begin
							rsp_w.response = usrh_pkg::RSP_STALL;
						end
					end
					usrh_pkg::REQ_GET_CONFIGURATION: begin
						if (req_w.setup_length != 16'd1 || !active) begin
							rsp_w.response = usrh_pkg::RSP_STALL;
						end else begin
							rsp_w.response = usrh_pkg::RSP_DATA;
							rsp_w.reply_length = 16'd1;
							rsp_w.reply_value = configured ? {8'h00, dev_q.cur_config} : '0;
						end
					end
					usrh_pkg::REQ_GET_STATUS: begin
						if (!active) begin
							rsp_w.response = usrh_pkg::RSP_STALL;
						end else begin
							rsp_w.response = usrh_pkg::RSP_DATA;
							rsp_w.reply_length = 16'd2;
							rsp_w.reply_value = {14'd0, dev_q.remote_wakeup, cfg_q.self_powered};
						end
					end
					usrh_pkg::REQ_SET_FEATURE: begin
						if (req_w.setup_value == usrh_pkg::FEAT_REMOTE_WAKEUP) begin
							dev_nxt.remote_wakeup = 1'b1;
							rsp_w.response = usrh_pkg::RSP_ACK;
						end
					end
					usrh_pkg::REQ_CLEAR_FEATURE: begin
						if (!active) begin
							rsp_w.response = usrh_pkg::RSP_STALL;
						end else if (req_w.setup_value == usrh_pkg::FEAT_REMOTE_WAKEUP) begin
							dev_nxt.remote_wakeup = 1'b0;
							rsp_w.response = usrh_pkg::RSP_ACK;
						end
					end
					default: rsp_w.response = usrh_pkg::RSP_STALL;
				endcase
			end
			usrh_pkg::RCPT_INTERFACE: begin
				if (!configured || req_w.setup_index[7:0] > cfg_q.max_interface) begin
					rsp_w.response = usrh_pkg::RSP_STALL;
				end else begin
					rsp_w.class_action = usrh_pkg::CA_INTERFACE;
					rsp_w.class_index = req_w.setup_index[7:0];
					if (req_w.setup_length == '0) rsp_w.response = usrh_pkg::RSP_ACK;
				end
			end
			usrh_pkg::RCPT_ENDPOINT: begin
				if (req_w.request_kind != usrh_pkg::KIND_CLASS &&
						(req_w.request_code == usrh_pkg::REQ_GET_STATUS ||
						req_w.request_code == usrh_pkg::REQ_CLEAR_FEATURE ||
						req_w.request_code == usrh_pkg::REQ_SET_FEATURE)) begin
					if (addressed) begin
						if (ep_num != '0) ep_cmd = usrh_pkg::EA_STALL;
					end else if (!configured) begin
						rsp_w.response = usrh_pkg::RSP_STALL;
					end else if (req_w.request_code == usrh_pkg::REQ_SET_FEATURE) begin
						if (req_w.setup_value == usrh_pkg::FEAT_ENDPOINT_HALT && ep_num != '0)
							ep_cmd = usrh_pkg::EA_STALL;
						rsp_w.response = usrh_pkg::RSP_ACK;
					end else if (req_w.request_code == usrh_pkg::REQ_CLEAR_FEATURE) begin
						if (req_w.setup_value == usrh_pkg::FEAT_ENDPOINT_HALT) begin
							if (ep_num != '0) ep_cmd = usrh_pkg::EA_CLEAR;
							rsp_w.response = usrh_pkg::RSP_ACK;
						end
					end else begin
						rsp_w.response = usrh_pkg::RSP_DATA;
						rsp_w.reply_length = 16'd2;
						rsp_w.reply_value = {15'd0, |(halt_sel & ep_mask)};
					end
				end
			end
			default: rsp_w.response = usrh_pkg::RSP_STALL;
		endcase
		rsp_w.endpoint_action = ep_cmd;
		if (ep_cmd != usrh_pkg::EA_NONE) rsp_w.endpoint_address = req_w.setup_index[7:0];
	end

	// halt bit update for the endpoint named in wIndex
	always_comb begin
		in_halt_nxt = in_halt_q;
		out_halt_nxt = out_halt_q;
		if (ep_cmd != usrh_pkg::EA_NONE) begin
			if (ep_in) begin
				in_halt_nxt = (ep_cmd == usrh_pkg::EA_STALL) ?
					(in_halt_q | ep_mask) : (in_halt_q & ~ep_mask);
			end else begin
				out_halt_nxt = (ep_cmd == usrh_pkg::EA_STALL) ?
					(out_halt_q | ep_mask) : (out_halt_q & ~ep_mask);
			end
		end
	end

endmodule

/* dv/usb_standard_request_handler_tb.sv */
// Testbench for the USB standard request handler: random and directed setup words.
module usb_standard_request_handler_tb;

	localparam int EP_COUNT = usrh_pkg::NumEndpointsDef;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [usrh_pkg::CfgIdxW-1:0] cfg_index;
	logic [usrh_pkg::CfgDataW-1:0] cfg_data;

	usrh_req_if req_ch();
	usrh_rsp_if rsp_ch();

	usb_standard_request_handler #(
		.NUM_ENDPOINTS(EP_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of registers and device state
	logic self_pw;
	logic [7:0] max_cfg;
	logic [7:0] max_itf;
	usrh_pkg::usb_state_t dev_st;
	logic [7:0] cur_cfg;
	logic wakeup;
	logic [6:0] addr_model;
	logic [15:0] in_halt;
	logic [15:0] out_halt;

	usrh_pkg::req_t setup_q[$];
	usrh_pkg::rsp_t reply_q[$];
	usrh_pkg::req_t tx_word;
	int tx_gap;
	int rx_gap;
	int rx_hold;
	int gap_mode;
	int holds_asked;
	int holds_served;
	int setups_sent;
	int replies_seen;
	int mismatch_cnt;
	int settings_cnt;
	int configured_hits;

	function automatic void update_halt(usrh_pkg::ep_act_t act, logic [7:0] ep);
		logic [15:0] m;
		m = (ep[6:0] < EP_COUNT) ? (16'd1 << ep[3:0]) : 16'd0;
		if (ep[7])
			in_halt = (act == usrh_pkg::EA_STALL) ? (in_halt | m) : (in_halt & ~m);
		else
			out_halt = (act == usrh_pkg::EA_STALL) ? (out_halt | m) : (out_halt & ~m);
	endfunction

	function automatic usrh_pkg::rsp_t decode_setup(usrh_pkg::req_t s);
		usrh_pkg::rsp_t r;
		logic [7:0] ep;
		logic [7:0] cfg;
		logic [2:0] sel;
		logic known;
		logic active;
		logic [15:0] bits;
		r = '0;
		ep = s.setup_index[7:0];
		cfg = s.setup_value[7:0];
		sel = '0;
		known = 1'b1;
		active = (dev_st == usrh_pkg::DS_ADDRESSED) || (dev_st == usrh_pkg::DS_CONFIGURED);
		if (s.action == usrh_pkg::RCPT_DEVICE) begin
			case (s.request_code)
			usrh_pkg::REQ_GET_DESCRIPTOR: begin
				if (s.setup_value[15:8] == usrh_pkg::DT_DEVICE)
					sel = usrh_pkg::DSEL_DEVICE;
				else if (s.setup_value[15:8] == usrh_pkg::DT_CONFIGURATION)
					sel = usrh_pkg::DSEL_CONFIGURATION;
				else if (s.setup_value[15:8] == usrh_pkg::DT_STRING &&
						s.setup_value[7:0] <= usrh_pkg::STRING_LAST)
					sel = usrh_pkg::DSEL_STRING_BASE + s.setup_value[2:0];
				else
					known = 1'b0;
				if (!known) begin
					r.response = usrh_pkg::RSP_STALL;
				end else if (s.setup_length != 16'd0) begin
					r.response = usrh_pkg::RSP_DESC;
					r.reply_length = s.setup_length;
					r.descriptor_select = sel;
				end
			end
			usrh_pkg::REQ_SET_ADDRESS: begin
				if (s.setup_index != 16'd0 || s.setup_length != 16'd0 ||
						dev_st == usrh_pkg::DS_CONFIGURED) begin
					r.response = usrh_pkg::RSP_STALL;
				end else begin
					addr_model = s.setup_value[6:0];
					r.address_write = 1'b1;
					r.new_address = addr_model;
					r.response = usrh_pkg::RSP_ACK;
					if (addr_model != 7'd0)
						dev_st = usrh_pkg::DS_ADDRESSED;
					else
						dev_st = usrh_pkg::DS_DEFAULT;
				end
			end
			usrh_pkg::REQ_SET_CONFIGURATION: begin
				if (cfg > max_cfg) begin
					r.response = usrh_pkg::RSP_STALL;
				end else if (dev_st == usrh_pkg::DS_ADDRESSED) begin
					r.response = usrh_pkg::RSP_ACK;
					if (cfg != 8'd0) begin
						cur_cfg = cfg;
						dev_st = usrh_pkg::DS_CONFIGURED;
						r.class_action = usrh_pkg::CA_SET;
						r.class_index = cfg;
						if (!s.class_ok) r.response = usrh_pkg::RSP_STALL;
					end
				end else if (dev_st == usrh_pkg::DS_CONFIGURED) begin
					r.response = usrh_pkg::RSP_ACK;
					if (cfg == 8'd0) begin
						r.class_action = usrh_pkg::CA_CLEAR;
						r.old_config = cur_cfg;
						dev_st = usrh_pkg::DS_ADDRESSED;
						cur_cfg = 8'd0;
					end else if (cfg != cur_cfg) begin
						r.class_action = usrh_pkg::CA_REPLACE;
						r.class_index = cfg;
						r.old_config = cur_cfg;
						cur_cfg = cfg;
						if (!s.class_ok) r.response = usrh_pkg::RSP_STALL;
					end
				end else begin
					r.response = usrh_pkg::RSP_STALL;
				end
			end
			usrh_pkg::REQ_GET_CONFIGURATION: begin
				if (s.setup_length != 16'd1 || !active) begin
					r.response = usrh_pkg::RSP_STALL;
				end else begin
					r.response = usrh_pkg::RSP_DATA;
					r.reply_length = 16'd1;
					r.reply_value = (dev_st == usrh_pkg::DS_CONFIGURED) ? {8'd0, cur_cfg} : 16'd0;
				end
			end
			usrh_pkg::REQ_GET_STATUS: begin
				if (!active) begin
					r.response = usrh_pkg::RSP_STALL;
				end else begin
					r.response = usrh_pkg::RSP_DATA;
					r.reply_length = 16'd2;
					r.reply_value = {14'd0, wakeup, self_pw};
				end
			end
			usrh_pkg::REQ_SET_FEATURE: begin
				if (s.setup_value == usrh_pkg::FEAT_REMOTE_WAKEUP) begin
					wakeup = 1'b1;
					r.response = usrh_pkg::RSP_ACK;
				end
			end
			usrh_pkg::REQ_CLEAR_FEATURE: begin
				if (!active) begin
					r.response = usrh_pkg::RSP_STALL;
				end else if (s.setup_value == usrh_pkg::FEAT_REMOTE_WAKEUP) begin
					wakeup = 1'b0;
					r.response = usrh_pkg::RSP_ACK;
				end
			end
			default: r.response = usrh_pkg::RSP_STALL;
			endcase
		end else if (s.action == usrh_pkg::RCPT_INTERFACE) begin
			if (dev_st != usrh_pkg::DS_CONFIGURED || ep > max_itf) begin
				r.response = usrh_pkg::RSP_STALL;
			end else begin
				r.class_action = usrh_pkg::CA_INTERFACE;
				r.class_index = ep;
				if (s.setup_length == 16'd0) r.response = usrh_pkg::RSP_ACK;
			end
		end else if (s.action == usrh_pkg::RCPT_ENDPOINT) begin
			if (s.request_kind == usrh_pkg::KIND_CLASS ||
					!(s.request_code inside {usrh_pkg::REQ_GET_STATUS,
					usrh_pkg::REQ_CLEAR_FEATURE, usrh_pkg::REQ_SET_FEATURE})) begin
				r.response = usrh_pkg::RSP_NONE;
			end else if (dev_st == usrh_pkg::DS_ADDRESSED) begin
				// only endpoint zero may be used before configuration
				if (ep[6:0] != 7'd0) begin
					r.endpoint_action = usrh_pkg::EA_STALL;
					r.endpoint_address = ep;
					update_halt(usrh_pkg::EA_STALL, ep);
				end
			end else if (dev_st != usrh_pkg::DS_CONFIGURED) begin
				r.response = usrh_pkg::RSP_STALL;
			end else if (s.request_code == usrh_pkg::REQ_SET_FEATURE) begin
				if (s.setup_value == usrh_pkg::FEAT_ENDPOINT_HALT && ep[6:0] != 7'd0) begin
					r.endpoint_action = usrh_pkg::EA_STALL;
					r.endpoint_address = ep;
					update_halt(usrh_pkg::EA_STALL, ep);
				end
				r.response = usrh_pkg::RSP_ACK;
			end else if (s.request_code == usrh_pkg::REQ_CLEAR_FEATURE) begin
				if (s.setup_value == usrh_pkg::FEAT_ENDPOINT_HALT) begin
					if (ep[6:0] != 7'd0) begin
						r.endpoint_action = usrh_pkg::EA_CLEAR;
						r.endpoint_address = ep;
						update_halt(usrh_pkg::EA_CLEAR, ep);
					end
					r.response = usrh_pkg::RSP_ACK;
				end
			end else begin
				bits = ep[7] ? in_halt : out_halt;
				r.response = usrh_pkg::RSP_DATA;
				r.reply_length = 16'd2;
				r.reply_value = {15'd0, (ep[6:0] < EP_COUNT) && bits[ep[3:0]]};
			end
		end else begin
			r.response = usrh_pkg::RSP_STALL;
		end
		return r;
	endfunction

	function automatic usrh_pkg::req_t mk(logic [1:0] act, logic [1:0] kind, logic [7:0] code,
			logic [15:0] val, logic [15:0] idx, logic [15:0] len, logic ok);
		usrh_pkg::req_t s;
		s.action = act;
		s.request_kind = kind;
		s.request_code = code;
		s.setup_value = val;
		s.setup_index = idx;
		s.setup_length = len;
		s.class_ok = ok;
		return s;
	endfunction

	function automatic logic [15:0] rand16();
		case ($urandom_range(0, 5))
		0: return 16'd0;
		1: return 16'hFFFF;
		2: return 16'd1;
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic usrh_pkg::req_t random_setup();
		usrh_pkg::req_t s;
		int pick;
		s = mk(usrh_pkg::RCPT_DEVICE, 2'd0, usrh_pkg::REQ_GET_STATUS, 16'd0, 16'd0, 16'd0,
			$urandom_range(0, 4) != 0);
		if ($urandom_range(0, 7) == 0) s.request_kind = 2'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			s.action = 2'($urandom);
			s.request_kind = 2'($urandom);
			s.request_code = 8'($urandom);
			s.setup_value = 16'($urandom);
			s.setup_index = 16'($urandom);
			s.setup_length = 16'($urandom);
			s.class_ok = 1'($urandom);
		end else if (pick < 18) begin
			s.request_code = usrh_pkg::REQ_SET_ADDRESS;
			s.setup_value = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
				16'($urandom_range(0, 127));
			if ($urandom_range(0, 9) == 0) s.setup_index = rand16();
			if ($urandom_range(0, 9) == 0) s.setup_length = rand16();
		end else if (pick < 33) begin
			s.request_code = usrh_pkg::REQ_SET_CONFIGURATION;
			case ($urandom_range(0, 5))
			0: s.setup_value = 16'($urandom);
			1: s.setup_value = {8'd0, max_cfg + 8'd1};
			2: s.setup_value = {8'd0, max_cfg};
			default: s.setup_value = 16'($urandom_range(0, (max_cfg < 4) ? max_cfg : 4));
			endcase
		end else if (pick < 43) begin
			s.request_code = usrh_pkg::REQ_GET_DESCRIPTOR;
			s.setup_value = {8'($urandom_range(0, 4)), 8'($urandom_range(0, 7))};
			s.setup_length = rand16();
		end else if (pick < 49) begin
			s.request_code = usrh_pkg::REQ_GET_CONFIGURATION;
			s.setup_length = ($urandom_range(0, 4) == 0) ? rand16() : 16'd1;
		end else if (pick < 55) begin
			s.setup_length = 16'd2;
		end else if (pick < 62) begin
			s.request_code = $urandom_range(0, 1) ? usrh_pkg::REQ_SET_FEATURE :
				usrh_pkg::REQ_CLEAR_FEATURE;
			s.setup_value = ($urandom_range(0, 3) == 0) ? rand16() :
				usrh_pkg::FEAT_REMOTE_WAKEUP;
		end else if (pick < 74) begin
			s.action = usrh_pkg::RCPT_INTERFACE;
			s.request_code = 8'($urandom);
			s.setup_index = {8'($urandom), 8'($urandom_range(0, max_itf + 1))};
			if ($urandom_range(0, 2) == 0) s.setup_index = 16'($urandom);
			s.setup_length = $urandom_range(0, 1) ? 16'd0 : rand16();
		end else begin
			s.action = usrh_pkg::RCPT_ENDPOINT;
			case ($urandom_range(0, 2))
			0: s.request_code = usrh_pkg::REQ_GET_STATUS;
			1: s.request_code = usrh_pkg::REQ_CLEAR_FEATURE;
			default: s.request_code = usrh_pkg::REQ_SET_FEATURE;
			endcase
			if ($urandom_range(0, 9) == 0) s.request_code = 8'($urandom);
			s.setup_value = ($urandom_range(0, 5) == 0) ? rand16() :
				usrh_pkg::FEAT_ENDPOINT_HALT;
			s.setup_index = {8'($urandom), 1'($urandom), 7'($urandom_range(0, EP_COUNT + 1))};
			if ($urandom_range(0, 7) == 0) s.setup_index[7:0] = 8'($urandom);
			s.setup_length = ($urandom_range(0, 3) == 0) ? rand16() : 16'd2;
		end
		return s;
	endfunction

	function automatic int pick_gap(int mode);
		int r;
		r = $urandom_range(0, 99);
		if (mode == 0) return 0;
		if (mode == 1) begin
			if (r < 65) return 0;
			if (r < 93) return $urandom_range(1, 3);
			return $urandom_range(8, 40);
		end
		if (r < 30) return 0;
		if (r < 85) return $urandom_range(1, 5);
		return $urandom_range(10, 60);
	endfunction

	function automatic void note_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("ERROR: response word %0d field %s: expected %0h, got %0h",
					replies_seen, name, want, got);
		end
	endfunction

	function automatic void check_reply();
		usrh_pkg::rsp_t want;
		usrh_pkg::rsp_t got;
		got = {rsp_ch.response, rsp_ch.reply_value, rsp_ch.reply_length,
			rsp_ch.descriptor_select, rsp_ch.class_action, rsp_ch.class_index,
			rsp_ch.old_config, rsp_ch.address_write, rsp_ch.new_address,
			rsp_ch.endpoint_action, rsp_ch.endpoint_address};
		replies_seen++;
		if (reply_q.size() == 0) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("ERROR: response word %0d with no request outstanding", replies_seen);
		end else begin
			want = reply_q.pop_front();
			note_field("response", 16'(want.response), 16'(got.response));
			note_field("reply_value", want.reply_value, got.reply_value);
			note_field("reply_length", want.reply_length, got.reply_length);
			note_field("descriptor_select", 16'(want.descriptor_select),
				16'(got.descriptor_select));
			note_field("class_action", 16'(want.class_action), 16'(got.class_action));
			note_field("class_index", 16'(want.class_index), 16'(got.class_index));
			note_field("old_config", 16'(want.old_config), 16'(got.old_config));
			note_field("address_write", 16'(want.address_write), 16'(got.address_write));
			note_field("new_address", 16'(want.new_address), 16'(got.new_address));
			note_field("endpoint_action", 16'(want.endpoint_action),
				16'(got.endpoint_action));
			note_field("endpoint_address", 16'(want.endpoint_address),
				16'(got.endpoint_address));
		end
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				if (dev_st == usrh_pkg::DS_CONFIGURED) configured_hits++;
				reply_q.push_back(decode_setup(tx_word));
				setups_sent++;
				tx_gap = pick_gap(gap_mode);
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (tx_gap == 0 && setup_q.size() != 0) begin
					tx_word = setup_q.pop_front();
					req_ch.action <= tx_word.action;
					req_ch.request_kind <= tx_word.request_kind;
					req_ch.request_code <= tx_word.request_code;
					req_ch.setup_value <= tx_word.setup_value;
					req_ch.setup_index <= tx_word.setup_index;
					req_ch.setup_length <= tx_word.setup_length;
					req_ch.class_ok <= tx_word.class_ok;
					req_ch.valid <= 1'b1;
				end else begin
					if (tx_gap != 0) tx_gap--;
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rx_gap = 0;
			rx_hold = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) check_reply();
			if (holds_served != holds_asked) begin
				rx_hold = HOLD_CYCLES;
				holds_served++;
			end
			if (rx_hold != 0) begin
				rx_hold--;
				rsp_ch.ready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				rx_gap = pick_gap(gap_mode);
			end
		end
	end

	task automatic wait_drained();
		while (setup_q.size() != 0 || req_ch.valid || reply_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic configure(logic sp, logic [7:0] mc, logic [7:0] mi);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= usrh_pkg::CFG_SELF_POWERED;
		cfg_data <= {7'd0, sp};
		@(posedge clk);
		cfg_index <= usrh_pkg::CFG_MAX_CONFIGURATION;
		cfg_data <= mc;
		@(posedge clk);
		cfg_index <= usrh_pkg::CFG_MAX_INTERFACE;
		cfg_data <= mi;
		@(posedge clk);
		cfg_we <= 1'b0;
		self_pw = sp;
		max_cfg = mc;
		max_itf = mi;
		settings_cnt++;
	endtask

	task automatic queue_random(int n);
		repeat (n) setup_q.push_back(random_setup());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.action = '0;
		req_ch.request_kind = '0;
		req_ch.request_code = '0;
		req_ch.setup_value = '0;
		req_ch.setup_index = '0;
		req_ch.setup_length = '0;
		req_ch.class_ok = 1'b0;
		rsp_ch.ready = 1'b0;
		self_pw = 1'b0;
		max_cfg = 8'd1;
		max_itf = 8'd1;
		dev_st = usrh_pkg::DS_DEFAULT;
		cur_cfg = 8'd0;
		wakeup = 1'b0;
		addr_model = 7'd0;
		in_halt = '0;
		out_halt = '0;
		gap_mode = 1;
		holds_asked = 0;
		holds_served = 0;
		setups_sent = 0;
		replies_seen = 0;
		mismatch_cnt = 0;
		settings_cnt = 0;
		configured_hits = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed words, starting from the default state
		configure(1'b1, 8'd2, 8'd0);
		setup_q.push_back(mk(usrh_pkg::RCPT_DEVICE, 2'd0, usrh_pkg::REQ_GET_STATUS,
			16'd0, 16'd0, 16'd2, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_DEVICE, 2'd0, usrh_pkg::REQ_GET_DESCRIPTOR,
			{usrh_pkg::DT_DEVICE, 8'h00}, 16'd0, 16'hFFFF, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_DEVICE, 2'd0, usrh_pkg::REQ_GET_DESCRIPTOR,
			{usrh_pkg::DT_STRING, usrh_pkg::STRING_LAST}, 16'd0, 16'd0, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_DEVICE, 2'd0, usrh_pkg::REQ_GET_DESCRIPTOR,
			{usrh_pkg::DT_STRING, 8'd6}, 16'd0, 16'd64, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_DEVICE, 2'd0, usrh_pkg::REQ_SET_FEATURE,
			usrh_pkg::FEAT_REMOTE_WAKEUP, 16'd0, 16'd0, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_DEVICE, 2'd0, usrh_pkg::REQ_SET_FEATURE,
			16'h0002, 16'd0, 16'd0, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_DEVICE, 2'd0, usrh_pkg::REQ_CLEAR_FEATURE,
			usrh_pkg::FEAT_REMOTE_WAKEUP, 16'd0, 16'd0, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_ENDPOINT, 2'd0, usrh_pkg::REQ_GET_STATUS,
			16'd0, 16'h0081, 16'd2, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_INTERFACE, 2'd0, 8'h0A, 16'd0, 16'd0, 16'd0, 1'b1));
		setup_q.push_back(mk(2'd3, 2'd3, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_DEVICE, 2'd0, 8'hFF, 16'd0, 16'd0, 16'd0, 1'b0));
		setup_q.push_back(mk(usrh_pkg::RCPT_DEVICE, 2'd0, usrh_pkg::REQ_SET_ADDRESS,
			16'h007F, 16'd0, 16'd0, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_ENDPOINT, 2'd0, usrh_pkg::REQ_SET_FEATURE,
			usrh_pkg::FEAT_ENDPOINT_HALT, 16'hFF81, 16'd0, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_DEVICE, 2'd0, usrh_pkg::REQ_GET_CONFIGURATION,
			16'd0, 16'd0, 16'd1, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_DEVICE, 2'd0, usrh_pkg::REQ_SET_CONFIGURATION,
			16'd1, 16'd0, 16'd0, 1'b0));
		setup_q.push_back(mk(usrh_pkg::RCPT_DEVICE, 2'd0, usrh_pkg::REQ_SET_CONFIGURATION,
			16'd2, 16'd0, 16'd0, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_DEVICE, 2'd0, usrh_pkg::REQ_GET_STATUS,
			16'd0, 16'd0, 16'd2, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_DEVICE, 2'd0, usrh_pkg::REQ_SET_ADDRESS,
			16'd5, 16'd0, 16'd0, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_ENDPOINT, 2'd0, usrh_pkg::REQ_GET_STATUS,
			16'd0, 16'h0081, 16'd2, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_ENDPOINT, 2'd0, usrh_pkg::REQ_CLEAR_FEATURE,
			usrh_pkg::FEAT_ENDPOINT_HALT, 16'h0081, 16'd0, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_ENDPOINT, 2'd0, usrh_pkg::REQ_SET_FEATURE,
			usrh_pkg::FEAT_ENDPOINT_HALT, 16'h0010, 16'd0, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_ENDPOINT, usrh_pkg::KIND_CLASS,
			usrh_pkg::REQ_SET_FEATURE, usrh_pkg::FEAT_ENDPOINT_HALT, 16'h0002, 16'd0, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_ENDPOINT, 2'd0, 8'h07, 16'd0, 16'h0002, 16'd0, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_INTERFACE, 2'd0, 8'h0B, 16'd0, 16'd0, 16'd0, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_INTERFACE, 2'd0, 8'h0B, 16'd0, 16'd0, 16'd8, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_INTERFACE, 2'd0, 8'h0B, 16'd0, 16'd1, 16'd0, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_DEVICE, 2'd0, usrh_pkg::REQ_SET_CONFIGURATION,
			16'd3, 16'd0, 16'd0, 1'b1));
		setup_q.push_back(mk(usrh_pkg::RCPT_DEVICE, 2'd0, usrh_pkg::REQ_SET_CONFIGURATION,
			16'd0, 16'd0, 16'd0, 1'b1));
		wait_drained();

		configure(1'b0, 8'd3, 8'd2);
		gap_mode = 0;
		queue_random(200);
		wait_drained();

		// long receiver hold while the sender keeps offering words
		configure(1'b1, 8'd255, 8'd255);
		gap_mode = 1;
		queue_random(200);
		holds_asked++;
		wait_drained();

		// sender pauses mid-phase until every response is in
		configure(1'b0, 8'd1, 8'd1);
		gap_mode = 2;
		queue_random(100);
		wait_drained();
		queue_random(100);
		holds_asked++;
		wait_drained();

		configure(1'($urandom), 8'($urandom_range(1, 255)), 8'($urandom));
		gap_mode = 1;
		queue_random(150);
		wait_drained();

		repeat (20) @(posedge clk);
		$display("Sent %0d setup words under %0d register settings, %0d response words checked",
			setups_sent, settings_cnt, replies_seen);
		$display("%0d words met the configured state, %0d field mismatches",
			configured_hits, mismatch_cnt);
		if (mismatch_cnt == 0 && reply_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5000000;
		$display("Timeout: %0d responses outstanding", reply_q.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

/* filelist.f */
rtl/usrh_pkg.sv
rtl/usrh_req_if.sv
rtl/usrh_rsp_if.sv
rtl/usrh_state.sv
rtl/usrh_decode.sv
rtl/usb_standard_request_handler.sv
dv/usb_standard_request_handler_tb.sv
